@@ src/assert_macros.svh @@
// Assertion helpers for the RTL; included by dive_mission_sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ src/dms_pkg.sv @@
`default_nettype none

package dms_pkg;

  // Entry window default, milliseconds
  localparam int ENTRY_WINDOW_MS_DEFAULT = 50;

  // Event kinds
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  // Safety causes
  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_LEAK     = 2'd1;
  localparam logic [1:0] CAUSE_LOW_BATT = 2'd2;

  // Propulsion commands
  localparam logic [1:0] DRIVE_STOP = 2'd0;
  localparam logic [1:0] DRIVE_MOVE = 2'd1;
  localparam logic [1:0] DRIVE_TURN = 2'd2;

  // Rudder angles, degrees
  localparam logic [7:0] SERVO_CENTER = 8'd90;
  localparam logic [7:0] SERVO_TURN   = 8'd65;

  // Configuration register indexes
  localparam logic [2:0] REG_TARGET_DEPTH    = 3'd0;
  localparam logic [2:0] REG_DEPTH_MARGIN    = 3'd1;
  localparam logic [2:0] REG_SURFACE_DEPTH   = 3'd2;
  localparam logic [2:0] REG_MOVE_DURATION   = 3'd3;
  localparam logic [2:0] REG_TURN_DURATION   = 3'd4;
  localparam logic [2:0] REG_DESCEND_TIMEOUT = 3'd5;
  localparam logic [2:0] REG_ASCEND_TIMEOUT  = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_DESC = 3'd1,
    PH_MOVE = 3'd2,
    PH_TURN = 3'd3,
    PH_ASC  = 3'd4,
    PH_EMER = 3'd5,
    PH_DONE = 3'd6
  } phase_t;

  typedef struct packed {
    logic [15:0] target_depth_mm;
    logic [15:0] depth_margin_mm;
    logic [15:0] surface_depth_mm;
    logic [31:0] move_duration_ms;
    logic [31:0] turn_duration_ms;
    logic [31:0] descend_timeout_ms;
    logic [31:0] ascend_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        now_ms;
    logic signed [15:0] depth_mm;
    logic [1:0]         safety_cause;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic        run_flag;
    logic [31:0] phase_start_ms;
    logic [1:0]  latched_cause;
    logic [1:0]  drive_hold;
    logic [7:0]  servo_hold;
    logic        ballast_hold;
  } state_t;

  typedef struct packed {
    logic [2:0] mission_state;
    logic       running;
    logic [1:0] drive_level;
    logic [7:0] servo_angle_deg;
    logic       ballast_vent;
    logic       depth_hold_request;
    logic [1:0] emergency_cause;
  } result_t;

endpackage

`default_nettype wire

@@ src/dms_step.sv @@
`default_nettype none

// Next-state and result logic for one event.
module dms_step #(
  parameter int ENTRY_WINDOW_MS = dms_pkg::ENTRY_WINDOW_MS_DEFAULT
) (
  input  dms_pkg::cfg_t    cfg,
  input  dms_pkg::state_t  st,
  input  dms_pkg::item_t   item,
  output dms_pkg::state_t  st_next,
  output dms_pkg::result_t res
);
  import dms_pkg::*;

  logic               cause_valid;
  logic [1:0]         cause_latched;
  logic               em_enter;
  logic [31:0]        start_eff;
  logic [31:0]        elapsed;
  logic               entry;
  logic signed [17:0] depth_err;
  logic [17:0]        depth_err_abs;
  logic               at_target;
  logic               at_surface;
  logic               hold;
  state_t             nx;

  // Cause latch and emergency entry
  assign cause_valid   = (item.safety_cause == CAUSE_LEAK) ||
                         (item.safety_cause == CAUSE_LOW_BATT);
  assign cause_latched = (cause_valid && st.latched_cause == CAUSE_NONE) ?
                         item.safety_cause : st.latched_cause;
  assign em_enter      = (cause_latched != CAUSE_NONE) && (st.phase != PH_EMER);

  // Time in phase, measured after a possible emergency entry
  assign start_eff = em_enter ? item.now_ms : st.phase_start_ms;
  assign elapsed   = item.now_ms - start_eff;
  assign entry     = elapsed < 32'(ENTRY_WINDOW_MS);

  // Depth windows
  assign depth_err     = 18'(signed'({{2{item.depth_mm[15]}}, item.depth_mm})) -
                         signed'({2'b00, cfg.target_depth_mm});
  assign depth_err_abs = depth_err[17] ? 18'(-depth_err) : 18'(depth_err);
  assign at_target     = depth_err_abs < {2'b00, cfg.depth_margin_mm};
  assign at_surface    = signed'({item.depth_mm[15], item.depth_mm}) <
                         signed'({1'b0, cfg.surface_depth_mm});

  always_comb begin
    nx   = st;
    hold = 1'b0;
    unique case (item.operation)
      OP_UPDATE: begin
        nx.latched_cause = cause_latched;
        if (em_enter) begin
          nx.phase          = PH_EMER;
          nx.phase_start_ms = item.now_ms;
        end
        if (nx.run_flag || nx.phase == PH_EMER) begin
          unique case (nx.phase)
            PH_DESC: begin
              hold = 1'b1;
              if (at_target || elapsed > cfg.descend_timeout_ms) begin
                nx.phase          = PH_MOVE;
                nx.phase_start_ms = item.now_ms;
              end
            end
            PH_MOVE: begin
              if (entry) begin
                nx.servo_hold = SERVO_CENTER;
                nx.drive_hold = DRIVE_MOVE;
              end
              hold = 1'b1;
              if (elapsed >= cfg.move_duration_ms) begin
                nx.phase          = PH_TURN;
                nx.phase_start_ms = item.now_ms;
              end
            end
            PH_TURN: begin
              if (entry) begin
                nx.servo_hold = SERVO_TURN;
                nx.drive_hold = DRIVE_TURN;
              end
              hold = 1'b1;
              if (elapsed >= cfg.turn_duration_ms) begin
                nx.phase          = PH_ASC;
                nx.phase_start_ms = item.now_ms;
              end
            end
            PH_ASC: begin
              if (entry) nx.ballast_hold = 1'b1;
              if (at_surface || elapsed > cfg.ascend_timeout_ms) begin
                nx.phase          = PH_DONE;
                nx.phase_start_ms = item.now_ms;
              end
            end
            PH_EMER: begin
              nx.ballast_hold = 1'b1;
              nx.servo_hold   = SERVO_CENTER;
              nx.drive_hold   = DRIVE_STOP;
            end
            PH_DONE: begin
              if (entry) begin
                nx.drive_hold = DRIVE_STOP;
                nx.servo_hold = SERVO_CENTER;
              end
              nx.run_flag = 1'b0;
            end
            default: ;
          endcase
        end
      end
      OP_START: begin
        nx.run_flag       = 1'b1;
        nx.phase          = PH_DESC;
        nx.phase_start_ms = item.now_ms;
      end
      OP_STOP: begin
        nx.run_flag       = 1'b0;
        nx.drive_hold     = DRIVE_STOP;
        nx.phase          = PH_IDLE;
        nx.phase_start_ms = item.now_ms;
      end
      default: ;
    endcase
  end

  assign st_next = nx;

  // Result after the event
  assign res.mission_state      = nx.phase;
  assign res.running            = nx.run_flag;
  assign res.drive_level        = nx.drive_hold;
  assign res.servo_angle_deg    = nx.servo_hold;
  assign res.ballast_vent       = nx.ballast_hold;
  assign res.depth_hold_request = hold;
  assign res.emergency_cause    = nx.latched_cause;

endmodule

`default_nettype wire

@@ src/dive_mission_sequencer.sv @@
`default_nettype none

// Dive mission sequencer. Events (update, start, stop) come in on the s_ side,
// one result per event goes out on the m_ side in event order. One event is
// taken every clock cycle unless a full result register waits on m_tready;
// each event passes the input register, then the result register. The clock
// period is set by the combinational event step: a 32-bit elapsed-time
// subtract feeding the duration and timeout compares. Config
// registers are written through the cfg_ channel, which is always ready;
// write them only while no event is in flight.
module dive_mission_sequencer #(
  parameter int ENTRY_WINDOW_MS = dms_pkg::ENTRY_WINDOW_MS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Event stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [31:0] now_ms, [47:32] depth_mm, [49:48] safety_cause, [55:50] zero
  input  wire logic [55:0] s_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_tuser,
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] mission_state, [3] running, [5:4] drive_level,
  // [13:6] servo_angle_deg, [14] ballast_vent, [15] depth_hold_request,
  // [17:16] emergency_cause, [23:18] zero
  output logic [23:0]      m_tdata,
  // Configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import dms_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  result_t step_res;
  result_t res_q;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_depth_mm    <= 16'd300;
      cfg.depth_margin_mm    <= 16'd100;
      cfg.surface_depth_mm   <= 16'd200;
      cfg.move_duration_ms   <= 32'd10000;
      cfg.turn_duration_ms   <= 32'd3000;
      cfg.descend_timeout_ms <= 32'd30000;
      cfg.ascend_timeout_ms  <= 32'd15000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET_DEPTH:    cfg.target_depth_mm    <= cfg_data[15:0];
        REG_DEPTH_MARGIN:    cfg.depth_margin_mm    <= cfg_data[15:0];
        REG_SURFACE_DEPTH:   cfg.surface_depth_mm   <= cfg_data[15:0];
        REG_MOVE_DURATION:   cfg.move_duration_ms   <= cfg_data;
        REG_TURN_DURATION:   cfg.turn_duration_ms   <= cfg_data;
        REG_DESCEND_TIMEOUT: cfg.descend_timeout_ms <= cfg_data;
        REG_ASCEND_TIMEOUT:  cfg.ascend_timeout_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 moves on when the result register is free or drains
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_item.operation    <= s_tuser;
      s1_item.now_ms       <= s_tdata[31:0];
      s1_item.depth_mm     <= signed'(s_tdata[47:32]);
      s1_item.safety_cause <= s_tdata[49:48];
    end
  end

  dms_step #(
    .ENTRY_WINDOW_MS(ENTRY_WINDOW_MS)
  ) u_step (
    .cfg    (cfg),
    .st     (st),
    .item   (s1_item),
    .st_next(st_next),
    .res    (step_res)
  );

  // Sequencer state, updated as each request leaves stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_IDLE;
      st.run_flag       <= 1'b0;
      st.phase_start_ms <= 32'd0;
      st.latched_cause  <= CAUSE_NONE;
      st.drive_hold     <= DRIVE_STOP;
      st.servo_hold     <= SERVO_CENTER;
      st.ballast_hold   <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= step_res;
  end

  assign m_tdata = {6'b000000, res_q.emergency_cause, res_q.depth_hold_request,
                    res_q.ballast_vent, res_q.servo_angle_deg, res_q.drive_level,
                    res_q.running, res_q.mission_state};

  // Checks
  `include "assert_macros.svh"

  `ASSERT_NEXT(a_cause_sticky, clk, rst, st.latched_cause != CAUSE_NONE, $stable(st.latched_cause))
  `ASSERT_NEXT(a_vent_sticky, clk, rst, st.ballast_hold, st.ballast_hold)
  `ASSERT_IMPLIES(a_emer_vents, clk, rst, st.phase == PH_EMER, st.ballast_hold)
  `ASSERT_NEXT(a_result_loaded, clk, rst, advance, m_tvalid)

endmodule

`default_nettype wire
